[rtl/bgs_pkg.sv]
`timescale 1ns / 1ps
package bgs_pkg;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] REG_KERNEL_MODE = 2'd2;

	localparam logic KERNEL_KEYS    = 1'b0;
	localparam logic KERNEL_BSPLINE = 1'b1;

	localparam int CFG_BITS = 7;
	localparam int POS_BITS = 14;
	localparam int IDX_BITS = 6;
	localparam int WFRAC    = 14;
	localparam int WW       = 16;

	// reciprocal of three, exact for values below 2^17
	localparam int RECIP_SHIFT = 17;
	localparam logic [RECIP_SHIFT-1:0] RECIP3 = 17'd43691;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WGT,
		ST_WWAIT,
		ST_MAC,
		ST_MWAIT,
		ST_RND,
		ST_SAT,
		ST_OUT
	} bgs_state_t;

endpackage

[rtl/bicubic_grid_sampler.sv]
`timescale 1ns / 1ps
// write item: taken from the queue head straight into the grid memory while idle
// sample item: worked from queue head to result, one item at a time;
// eight 1-d weights through a six-stage weight pipe, then sixteen taps
// through the single grid read port and one multiply-accumulate each
// a two-entry queue takes new items while a sample is worked or a result waits
// reset clears control state and sets 64x64 extent, keys kernel; grid undefined
module bicubic_grid_sampler #(
	parameter int GRID_W_MAX  = 64,
	parameter int GRID_H_MAX  = 64,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [bgs_pkg::CFG_BITS-1:0]    cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            action,
	input  logic [bgs_pkg::IDX_BITS-1:0]    write_column,
	input  logic [bgs_pkg::IDX_BITS-1:0]    write_row,
	input  logic signed [SAMPLE_BITS-1:0]   write_value,
	input  logic [bgs_pkg::POS_BITS-1:0]    sample_x,
	input  logic [bgs_pkg::POS_BITS-1:0]    sample_y,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [SAMPLE_BITS-1:0]   sample_value,
	output logic                            saturated
);
	import bgs_pkg::*;

	localparam int AW  = $clog2(GRID_W_MAX * GRID_H_MAX);
	localparam int IXW = $clog2(GRID_W_MAX);
	localparam int IYW = $clog2(GRID_H_MAX);
	localparam int QW  = 2 + AW + SAMPLE_BITS + 2 * IXW + 2 * IYW + 2 * FRAC_BITS;

	logic          kernel_mode;
	logic          f_valid, f_ready;
	logic [QW-1:0] f_data;
	logic          b_valid, b_ready;
	logic [QW-1:0] b_data;

	bgs_front #(
		.GRID_W_MAX  (GRID_W_MAX),
		.GRID_H_MAX  (GRID_H_MAX),
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS),
		.QW          (QW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.write_column (write_column),
		.write_row    (write_row),
		.write_value  (write_value),
		.sample_x     (sample_x),
		.sample_y     (sample_y),
		.kernel_mode  (kernel_mode),
		.q_valid      (f_valid),
		.q_ready      (f_ready),
		.q_data       (f_data)
	);

	bgs_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	bgs_back #(
		.GRID_W_MAX  (GRID_W_MAX),
		.GRID_H_MAX  (GRID_H_MAX),
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS),
		.QW          (QW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.kernel_mode  (kernel_mode),
		.q_valid      (b_valid),
		.q_ready      (b_ready),
		.q_data       (b_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_value (sample_value),
		.saturated    (saturated)
	);
endmodule

[rtl/bgs_ram.sv]
`timescale 1ns / 1ps
module bgs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/bgs_queue.sv]
`timescale 1ns / 1ps
module bgs_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] slot_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = slot_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

[rtl/bgs_front.sv]
`timescale 1ns / 1ps
module bgs_front #(
	parameter int GRID_W_MAX  = 64,
	parameter int GRID_H_MAX  = 64,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 8,
	parameter int QW          = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [bgs_pkg::CFG_BITS-1:0]    cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            action,
	input  logic [bgs_pkg::IDX_BITS-1:0]    write_column,
	input  logic [bgs_pkg::IDX_BITS-1:0]    write_row,
	input  logic signed [SAMPLE_BITS-1:0]   write_value,
	input  logic [bgs_pkg::POS_BITS-1:0]    sample_x,
	input  logic [bgs_pkg::POS_BITS-1:0]    sample_y,
	output logic                            kernel_mode,
	output logic                            q_valid,
	input  logic                            q_ready,
	output logic [QW-1:0]                   q_data
);
	import bgs_pkg::*;

	localparam int AW  = $clog2(GRID_W_MAX * GRID_H_MAX);
	localparam int IXW = $clog2(GRID_W_MAX);
	localparam int IYW = $clog2(GRID_H_MAX);
	localparam int CXW = $clog2(GRID_W_MAX + 1);
	localparam int CYW = $clog2(GRID_H_MAX + 1);
	localparam int XW  = (IXW + FRAC_BITS > POS_BITS) ? IXW + FRAC_BITS : POS_BITS;
	localparam int YW  = (IYW + FRAC_BITS > POS_BITS) ? IYW + FRAC_BITS : POS_BITS;

	logic [CFG_BITS-1:0]  grid_width_q;
	logic [CFG_BITS-1:0]  grid_height_q;
	logic                 kernel_mode_q;
	logic [CXW-1:0]       wc;
	logic [CYW-1:0]       hc;
	logic [IXW-1:0]       wl;
	logic [IYW-1:0]       hl;
	logic [XW-1:0]        xmax;
	logic [YW-1:0]        ymax;
	logic [XW-1:0]        xc;
	logic [YW-1:0]        yc;
	logic [IXW-1:0]       ix;
	logic [IYW-1:0]       iy;
	logic [FRAC_BITS-1:0] fx;
	logic [FRAC_BITS-1:0] fy;
	logic                 wen;
	logic [AW-1:0]        waddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= CFG_BITS'(64);
			grid_height_q <= CFG_BITS'(64);
			kernel_mode_q <= KERNEL_KEYS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				REG_KERNEL_MODE: kernel_mode_q <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	assign kernel_mode = kernel_mode_q;

	// extent clamp, cell split and write address check
	always_comb begin
		if (grid_width_q == '0) begin
			wc = CXW'(1);
		end else if (32'(grid_width_q) > GRID_W_MAX) begin
			wc = CXW'(GRID_W_MAX);
		end else begin
			wc = CXW'(grid_width_q);
		end
		if (grid_height_q == '0) begin
			hc = CYW'(1);
		end else if (32'(grid_height_q) > GRID_H_MAX) begin
			hc = CYW'(GRID_H_MAX);
		end else begin
			hc = CYW'(grid_height_q);
		end
		wl   = IXW'(wc - CXW'(1));
		hl   = IYW'(hc - CYW'(1));
		xmax = XW'(wl) << FRAC_BITS;
		ymax = YW'(hl) << FRAC_BITS;
		xc   = (XW'(sample_x) > xmax) ? xmax : XW'(sample_x);
		yc   = (YW'(sample_y) > ymax) ? ymax : YW'(sample_y);
		ix   = IXW'(xc >> FRAC_BITS);
		iy   = IYW'(yc >> FRAC_BITS);
		fx   = xc[FRAC_BITS-1:0];
		fy   = yc[FRAC_BITS-1:0];
		wen  = (32'(write_column) < GRID_W_MAX) && (32'(write_row) < GRID_H_MAX);
		waddr = AW'(32'(write_row) * GRID_W_MAX + 32'(write_column));
	end

	assign q_valid  = in_valid;
	assign in_ready = q_ready;
	assign q_data   = {action, wen, waddr, write_value, ix, iy, fx, fy, wl, hl};
endmodule

[rtl/bgs_weight.sv]
`timescale 1ns / 1ps
module bgs_weight #(
	parameter int FRAC_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [2:0]                  in_idx,
	input  logic [FRAC_BITS-1:0]        in_frac,
	input  logic                        mode,
	output logic                        out_valid,
	output logic [2:0]                  out_idx,
	output logic signed [bgs_pkg::WW-1:0] out_weight
);
	import bgs_pkg::*;

	localparam int UW  = FRAC_BITS + 2;
	localparam int U2W = 2 * FRAC_BITS + 3;
	localparam int U3W = 3 * FRAC_BITS + 4;
	localparam int RW  = 3 * FRAC_BITS + 8;
	localparam int NW  = RW + WFRAC;
	localparam int MW  = 2 * RECIP_SHIFT;

	logic [5:0]           v_q;
	logic [2:0]           idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;
	logic [UW-1:0]        u, u_s1, u_s2, u_s3;
	logic [U2W-1:0]       u2_s2, u2_s3;
	logic [U3W-1:0]       u3_s3;
	logic signed [RW-1:0] raw, raw_s4;
	logic signed [RW-1:0] tu3, tu2f, tuf2, one3;
	logic [UW-1:0]        one_u;
	logic [RW-1:0]        mag;
	logic [NW-1:0]        kn, bt;
	logic [WW-1:0]        kmag;
	logic signed [WW-1:0] wk_s5, w_s6;
	logic [RECIP_SHIFT-1:0] bv_s5;
	logic [MW-1:0]        bq;

	assign one_u = UW'(1) << FRAC_BITS;

	always_comb begin
		unique case (in_idx[1:0])
			2'd0:    u = UW'(in_frac) + one_u;
			2'd1:    u = UW'(in_frac);
			2'd2:    u = one_u - UW'(in_frac);
			default: u = (one_u << 1) - UW'(in_frac);
		endcase
	end

	always_comb begin
		tu3  = $signed(RW'(u3_s3));
		tu2f = $signed(RW'(u2_s3)) <<< FRAC_BITS;
		tuf2 = $signed(RW'(u_s3)) <<< (2 * FRAC_BITS);
		one3 = $signed(RW'(1)) <<< (3 * FRAC_BITS);
		if (mode == KERNEL_KEYS) begin
			if (u_s3 <= one_u) begin
				raw = RW'(3 * tu3 - 5 * tu2f + 2 * one3);
			end else begin
				raw = RW'(-tu3 + 5 * tu2f - 8 * tuf2 + 4 * one3);
			end
		end else begin
			if (u_s3 < one_u) begin
				raw = RW'(3 * tu3 - 6 * tu2f + 4 * one3);
			end else if (u_s3 < (one_u << 1)) begin
				raw = RW'(8 * one3 - 12 * tuf2 + 6 * tu2f - tu3);
			end else begin
				raw = '0;
			end
		end
	end

	always_comb begin
		mag  = raw_s4[RW-1] ? RW'(-raw_s4) : RW'(raw_s4);
		kn   = (NW'(mag) << WFRAC) + (NW'(1) << (3 * FRAC_BITS));
		kmag = WW'(kn >> (3 * FRAC_BITS + 1));
		bt   = (NW'(raw_s4) << WFRAC) + (NW'(3) << (3 * FRAC_BITS));
		bq   = MW'(bv_s5) * MW'(RECIP3);
	end

	always_ff @(posedge clk) begin
		idx_s1 <= in_idx;
		u_s1   <= u;
		idx_s2 <= idx_s1;
		u_s2   <= u_s1;
		u2_s2  <= U2W'(U2W'(u_s1) * U2W'(u_s1));
		idx_s3 <= idx_s2;
		u_s3   <= u_s2;
		u2_s3  <= u2_s2;
		u3_s3  <= U3W'(U3W'(u2_s2) * U3W'(u_s2));
		idx_s4 <= idx_s3;
		raw_s4 <= raw;
		idx_s5 <= idx_s4;
		wk_s5  <= raw_s4[RW-1] ? WW'(-kmag) : WW'(kmag);
		bv_s5  <= RECIP_SHIFT'(bt >> (3 * FRAC_BITS + 1));
		idx_s6 <= idx_s5;
		w_s6   <= (mode == KERNEL_BSPLINE) ? WW'(bq >> RECIP_SHIFT) : wk_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[4:0], in_valid};
		end
	end

	assign out_valid  = v_q[5];
	assign out_idx    = idx_s6;
	assign out_weight = w_s6;
endmodule

[rtl/bgs_back.sv]
`timescale 1ns / 1ps
module bgs_back #(
	parameter int GRID_W_MAX  = 64,
	parameter int GRID_H_MAX  = 64,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 8,
	parameter int QW          = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          kernel_mode,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  logic [QW-1:0]                 q_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_value,
	output logic                          saturated
);
	import bgs_pkg::*;

	localparam int DEPTH = GRID_W_MAX * GRID_H_MAX;
	localparam int AW    = $clog2(DEPTH);
	localparam int IXW   = $clog2(GRID_W_MAX);
	localparam int IYW   = $clog2(GRID_H_MAX);
	localparam int PW    = 2 * WW + SAMPLE_BITS;
	localparam int ACW   = PW + 4;
	localparam int RNW   = ACW - 2 * WFRAC;
	localparam logic signed [ACW-1:0] HALF = ACW'(1) << (2 * WFRAC - 1);
	localparam logic signed [RNW-1:0] SMAX =
		RNW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [RNW-1:0] SMIN = -SMAX - RNW'(1);

	bgs_state_t state_q, nxt;

	logic                   c_op, c_wen;
	logic [AW-1:0]          c_waddr;
	logic [SAMPLE_BITS-1:0] c_wval;
	logic [IXW-1:0]         c_ix, c_wl;
	logic [IYW-1:0]         c_iy, c_hl;
	logic [FRAC_BITS-1:0]   c_fx, c_fy;

	logic [IXW-1:0]         ix_q, wl_q;
	logic [IYW-1:0]         iy_q, hl_q;
	logic [FRAC_BITS-1:0]   fx_q, fy_q;
	logic [3:0]             cnt_q;

	logic                   ram_we;
	logic                   w_issue;
	logic                   mac_issue;
	logic                   w_out_valid;
	logic [2:0]             w_out_idx;
	logic signed [WW-1:0]   w_out;
	logic signed [WW-1:0]   wx_q [4];
	logic signed [WW-1:0]   wy_q [4];

	logic signed [IYW+1:0]  rr;
	logic signed [IXW+1:0]  cc;
	logic [IYW-1:0]         r;
	logic [IXW-1:0]         c;
	logic [AW-1:0]          raddr;
	logic [SAMPLE_BITS-1:0] rdata;

	logic                   v_s1, v_s2, last_s1, last_s2, last_s3;
	logic signed [2*WW-1:0] wp_s1;
	logic signed [PW-1:0]   prod_s2;
	logic signed [ACW-1:0]  acc_q;
	logic signed [ACW-1:0]  acc_rnd;
	logic signed [RNW-1:0]  rnd_q;
	logic [SAMPLE_BITS-1:0] res_q;
	logic                   sat_q;
	logic                   out_valid_q;
	logic                   load_out;

	assign {c_op, c_wen, c_waddr, c_wval, c_ix, c_iy, c_fx, c_fy, c_wl, c_hl} = q_data;

	always_comb begin
		nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (q_valid && c_op == ACT_SAMPLE) nxt = ST_WGT;
			ST_WGT:   if (cnt_q == 4'd7) nxt = ST_WWAIT;
			ST_WWAIT: if (w_out_valid && w_out_idx == 3'd7) nxt = ST_MAC;
			ST_MAC:   if (cnt_q == 4'd15) nxt = ST_MWAIT;
			ST_MWAIT: if (last_s3) nxt = ST_RND;
			ST_RND:   nxt = ST_SAT;
			ST_SAT:   nxt = ST_OUT;
			ST_OUT:   if (!out_valid_q || out_ready) nxt = ST_IDLE;
			default:  nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready   = 1'b0;
		ram_we    = 1'b0;
		w_issue   = 1'b0;
		mac_issue = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				ram_we  = q_valid && c_op == ACT_WRITE && c_wen;
			end
			ST_WGT: w_issue = 1'b1;
			ST_MAC: mac_issue = 1'b1;
			ST_OUT: load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			last_s1     <= 1'b0;
			last_s2     <= 1'b0;
			last_s3     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt;
			cnt_q   <= (nxt != state_q) ? 4'd0 : cnt_q + 4'd1;
			v_s1    <= mac_issue;
			last_s1 <= mac_issue && cnt_q == 4'd15;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			last_s3 <= v_s2 && last_s2;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			ix_q <= c_ix;
			iy_q <= c_iy;
			fx_q <= c_fx;
			fy_q <= c_fy;
			wl_q <= c_wl;
			hl_q <= c_hl;
		end
		if (w_out_valid) begin
			if (w_out_idx[2]) begin
				wy_q[w_out_idx[1:0]] <= w_out;
			end else begin
				wx_q[w_out_idx[1:0]] <= w_out;
			end
		end
		wp_s1   <= (2*WW)'(wy_q[cnt_q[3:2]]) * (2*WW)'(wx_q[cnt_q[1:0]]);
		prod_s2 <= PW'(wp_s1) * PW'($signed(rdata));
		if (state_q == ST_WGT) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACW'(prod_s2);
		end
		rnd_q <= RNW'(acc_rnd >>> (2 * WFRAC));
		if (rnd_q > SMAX) begin
			res_q <= SAMPLE_BITS'(SMAX);
			sat_q <= 1'b1;
		end else if (rnd_q < SMIN) begin
			res_q <= SAMPLE_BITS'(SMIN);
			sat_q <= 1'b1;
		end else begin
			res_q <= SAMPLE_BITS'(rnd_q);
			sat_q <= 1'b0;
		end
		if (load_out) begin
			sample_value <= res_q;
			saturated    <= sat_q;
		end
	end

	assign acc_rnd = acc_q + HALF;

	// border clamped tap address
	always_comb begin
		rr = $signed((IYW+2)'(iy_q)) + $signed((IYW+2)'(cnt_q[3:2])) - (IYW+2)'(1);
		cc = $signed((IXW+2)'(ix_q)) + $signed((IXW+2)'(cnt_q[1:0])) - (IXW+2)'(1);
		if (rr[IYW+1]) begin
			r = '0;
		end else if (rr > $signed((IYW+2)'(hl_q))) begin
			r = hl_q;
		end else begin
			r = IYW'(rr);
		end
		if (cc[IXW+1]) begin
			c = '0;
		end else if (cc > $signed((IXW+2)'(wl_q))) begin
			c = wl_q;
		end else begin
			c = IXW'(cc);
		end
		raddr = AW'(32'(r) * GRID_W_MAX + 32'(c));
	end

	bgs_weight #(
		.FRAC_BITS (FRAC_BITS)
	) u_weight (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (w_issue),
		.in_idx     (cnt_q[2:0]),
		.in_frac    (cnt_q[2] ? fy_q : fx_q),
		.mode       (kernel_mode),
		.out_valid  (w_out_valid),
		.out_idx    (w_out_idx),
		.out_weight (w_out)
	);

	bgs_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (c_waddr),
		.wdata (c_wval),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign out_valid = out_valid_q;
endmodule
